// ===== sv/psd_pkg.sv =====
// Shared constants for the point to segment distance pipeline.
`timescale 1ns / 1ps
package psd_pkg;

  // Nearest region codes
  localparam logic [1:0] REGION_START = 2'd0;
  localparam logic [1:0] REGION_END   = 2'd1;
  localparam logic [1:0] REGION_MID   = 2'd2;

endpackage

// ===== sv/psd_front.sv =====
// Front stages: differences, products, region decision and root operands.
`timescale 1ns / 1ps
module psd_front #(
  parameter int CW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic signed [CW-1:0] px,
  input  logic signed [CW-1:0] py,
  input  logic signed [CW-1:0] sx,
  input  logic signed [CW-1:0] sy,
  input  logic signed [CW-1:0] ex,
  input  logic signed [CW-1:0] ey,
  output logic                 out_vld,
  output logic [1:0]           out_region,
  output logic [4*CW+3:0]      out_num,
  output logic [2*CW+2:0]      out_den
);
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW + 1;
  localparam int NW = 4 * CW + 4;
  localparam int EW = 2 * CW + 3;

  // stage 1: differences
  logic               v1_r;
  logic signed [DW-1:0] ux_r, uy_r, vx_r, vy_r, wx_r, wy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= in_vld;
    ux_r <= DW'(px) - DW'(sx);
    uy_r <= DW'(py) - DW'(sy);
    vx_r <= DW'(ex) - DW'(sx);
    vy_r <= DW'(ey) - DW'(sy);
    wx_r <= DW'(px) - DW'(ex);
    wy_r <= DW'(py) - DW'(ey);
  end

  // stage 2: single products
  logic v2_r;
  logic signed [PW-1:0] uxvx_r, uyvy_r, vxvx_r, vyvy_r, vxuy_r, vyux_r;
  logic signed [PW-1:0] uxux_r, uyuy_r, wxwx_r, wywy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    uxvx_r <= PW'(ux_r * vx_r);
    uyvy_r <= PW'(uy_r * vy_r);
    vxvx_r <= PW'(vx_r * vx_r);
    vyvy_r <= PW'(vy_r * vy_r);
    vxuy_r <= PW'(vx_r * uy_r);
    vyux_r <= PW'(vy_r * ux_r);
    uxux_r <= PW'(ux_r * ux_r);
    uyuy_r <= PW'(uy_r * uy_r);
    wxwx_r <= PW'(wx_r * wx_r);
    wywy_r <= PW'(wy_r * wy_r);
  end

  // stage 3: sums
  logic v3_r;
  logic signed [PW:0] d1_r, d2_r, cr_r, ls_r, le_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    d1_r <= (PW+1)'(uxvx_r) + (PW+1)'(uyvy_r);
    d2_r <= (PW+1)'(vxvx_r) + (PW+1)'(vyvy_r);
    cr_r <= (PW+1)'(vxuy_r) - (PW+1)'(vyux_r);
    ls_r <= (PW+1)'(uxux_r) + (PW+1)'(uyuy_r);
    le_r <= (PW+1)'(wxwx_r) + (PW+1)'(wywy_r);
  end

  // stage 4: region choice, cross magnitude
  logic v4_r;
  logic [1:0] reg4_r;
  logic [PW:0] mag_r, ls4_r, le4_r, d24_r;
  logic [1:0] reg4_nxt;
  always_comb begin
    if (d1_r <= 0)         reg4_nxt = psd_pkg::REGION_START;
    else if (d1_r >= d2_r) reg4_nxt = psd_pkg::REGION_END;
    else                   reg4_nxt = psd_pkg::REGION_MID;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    reg4_r <= reg4_nxt;
    mag_r  <= cr_r[PW] ? (PW+1)'(-cr_r) : (PW+1)'(cr_r);
    ls4_r  <= ls_r;
    le4_r  <= le_r;
    d24_r  <= d2_r;
  end

  // stage 5: numerator and denominator for the root search
  logic v5_r;
  logic [1:0] reg5_r;
  logic [NW-1:0] num_r;
  logic [EW-1:0] den_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= v4_r;
    reg5_r <= reg4_r;
    case (reg4_r)
      psd_pkg::REGION_START: begin
        num_r <= NW'(ls4_r);
        den_r <= EW'(1);
      end
      psd_pkg::REGION_END: begin
        num_r <= NW'(le4_r);
        den_r <= EW'(1);
      end
      default: begin
        num_r <= NW'(mag_r * mag_r);
        den_r <= EW'(d24_r);
      end
    endcase
  end

  assign out_vld    = v5_r;
  assign out_region = reg5_r;
  assign out_num    = num_r;
  assign out_den    = den_r;
endmodule

// ===== sv/psd_root.sv =====
// Pipelined bitwise search for the largest q with q*q*den <= num.
`timescale 1ns / 1ps
module psd_root #(
  parameter int CW = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [1:0]        in_region,
  input  logic [4*CW+3:0]   in_num,
  input  logic [2*CW+2:0]   in_den,
  output logic              out_vld,
  output logic [1:0]        out_region,
  output logic [CW:0]       out_q
);
  localparam int DW = CW + 1;
  localparam int NW = 4 * CW + 4;
  localparam int EW = 2 * CW + 3;
  localparam int SW = 2 * DW;
  localparam int NS = DW;

  // per step: candidate square is registered, then multiplied and compared
  logic            v_r   [NS+1];
  logic [1:0]      rg_r  [NS+1];
  logic [NW-1:0]   nm_r  [NS+1];
  logic [EW-1:0]   dn_r  [NS+1];
  logic [DW-1:0]   q_r   [NS+1];
  logic            va_r  [NS];
  logic [1:0]      rga_r [NS];
  logic [NW-1:0]   nma_r [NS];
  logic [EW-1:0]   dna_r [NS];
  logic [DW-1:0]   qa_r  [NS];
  logic [DW-1:0]   ta_r  [NS];
  logic [SW-1:0]   tt_r  [NS];

  always_comb begin
    v_r[0]  = in_vld;
    rg_r[0] = in_region;
    nm_r[0] = in_num;
    dn_r[0] = in_den;
    q_r[0]  = '0;
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    localparam int B = NS - 1 - i;
    logic [DW-1:0] t;
    logic [NW+EW-1:0] prod;
    assign t = q_r[i] | (DW'(1) << B);
    // half step a: square the candidate
    always_ff @(posedge clk) begin
      if (!rst_n) va_r[i] <= 1'b0;
      else        va_r[i] <= v_r[i];
      rga_r[i] <= rg_r[i];
      nma_r[i] <= nm_r[i];
      dna_r[i] <= dn_r[i];
      qa_r[i]  <= q_r[i];
      ta_r[i]  <= t;
      tt_r[i]  <= SW'(t * t);
    end
    // half step b: scale by denominator and compare
    assign prod = (NW+EW)'(tt_r[i]) * (NW+EW)'(dna_r[i]);
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else        v_r[i+1] <= va_r[i];
      rg_r[i+1] <= rga_r[i];
      nm_r[i+1] <= nma_r[i];
      dn_r[i+1] <= dna_r[i];
      q_r[i+1]  <= (prod <= (NW+EW)'(nma_r[i])) ? ta_r[i] : qa_r[i];
    end
  end

  assign out_vld    = v_r[NS];
  assign out_region = rg_r[NS];
  assign out_q      = q_r[NS];
endmodule

// ===== sv/point_segment_distance.sv =====
// Top level: point to segment distance, fully pipelined.
//
// channel | ports                          | handshake
// input   | in_point_*, in_seg_*           | start high, busy low
// result  | out_distance, out_nearest_region | out_valid, one cycle
//
// One item may enter every cycle; busy is always low.
// Results pass the front stages, the half steps of the bitwise root search and the output register.
// Synchronous reset clears every valid bit; payload is not reset.
// The receiver cannot stall, so results leave in order.
`timescale 1ns / 1ps
module point_segment_distance #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_seg_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_seg_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_seg_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_seg_end_y,
  output logic                          out_valid,
  output logic [COORD_WIDTH:0]          out_distance,
  output logic [1:0]                    out_nearest_region
);
  localparam int CW = COORD_WIDTH;

  logic             f_vld;
  logic [1:0]       f_region;
  logic [4*CW+3:0]  f_num;
  logic [2*CW+2:0]  f_den;
  logic             r_vld;
  logic [1:0]       r_region;
  logic [CW:0]      r_q;

  assign busy = 1'b0;

  psd_front #(.CW(CW)) u_front (
    .clk, .rst_n, .in_vld(start),
    .px(in_point_x), .py(in_point_y),
    .sx(in_seg_start_x), .sy(in_seg_start_y),
    .ex(in_seg_end_x), .ey(in_seg_end_y),
    .out_vld(f_vld), .out_region(f_region), .out_num(f_num), .out_den(f_den)
  );

  psd_root #(.CW(CW)) u_root (
    .clk, .rst_n, .in_vld(f_vld), .in_region(f_region), .in_num(f_num),
    .in_den(f_den), .out_vld(r_vld), .out_region(r_region), .out_q(r_q)
  );

  // output register
  logic            out_valid_r;
  logic [CW:0]     out_distance_r;
  logic [1:0]      out_region_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= r_vld;
    out_distance_r <= r_q;
    out_region_r   <= r_region;
  end
  assign out_valid          = out_valid_r;
  assign out_distance       = out_distance_r;
  assign out_nearest_region = out_region_r;

  // a valid result never carries the unused region code
  a_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_nearest_region != 2'd3)) else $error("bad region");
  // nothing leaves the pipe right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
  // block never refuses a transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
endmodule

// ===== sim/point_segment_distance_tb.sv =====
// Testbench for the point to segment distance pipeline.
`timescale 1ns / 1ps
module point_segment_distance_tb;

  localparam int CW = 16;
  localparam int DW = CW + 1;
  localparam int LATENCY = 6 + 2 * DW;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic signed [CW-1:0] px, py, sx, sy, ex, ey;
  } query_t;

  typedef struct packed {
    logic [DW-1:0] distance;
    logic [1:0]    region;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] in_point_x = '0, in_point_y = '0;
  logic signed [CW-1:0] in_seg_start_x = '0, in_seg_start_y = '0;
  logic signed [CW-1:0] in_seg_end_x = '0, in_seg_end_y = '0;
  logic out_valid;
  logic [CW:0] out_distance;
  logic [1:0] out_nearest_region;

  query_t  pending_queries[$];
  answer_t expected_answers[$];
  int      idle_pct = 0;
  bit      failed = 0;
  int      quiet_cycles = 0;

  point_segment_distance #(.COORD_WIDTH(CW)) dut (.*);

  always #4 clk = ~clk;

  // Floor square root of a 64-bit sum of squares
  function automatic logic [DW-1:0] floor_root(input logic [63:0] s);
    logic [DW-1:0] q;
    logic [DW-1:0] t;
    q = '0;
    for (int b = DW - 1; b >= 0; b--) begin
      t = q | (DW'(1) << b);
      if ({47'd0, t} * {47'd0, t} <= s) q = t;
    end
    return q;
  endfunction

  // Exact distance and nearest region of a point to a segment
  function automatic answer_t segment_distance(input query_t q);
    answer_t a;
    longint ux, uy, vx, vy, wx, wy, d1, d2, cr;
    logic [127:0] c2, lhs;
    logic [DW-1:0] r, t;
    ux = q.px - q.sx; uy = q.py - q.sy;
    vx = q.ex - q.sx; vy = q.ey - q.sy;
    wx = q.px - q.ex; wy = q.py - q.ey;
    d1 = ux * vx + uy * vy;
    d2 = vx * vx + vy * vy;
    if (d1 <= 0) begin
      a.region = psd_pkg::REGION_START;
      a.distance = floor_root(ux * ux + uy * uy);
    end else if (d1 >= d2) begin
      a.region = psd_pkg::REGION_END;
      a.distance = floor_root(wx * wx + wy * wy);
    end else begin
      a.region = psd_pkg::REGION_MID;
      cr = vx * uy - vy * ux;
      if (cr < 0) cr = -cr;
      c2 = 128'(cr) * 128'(cr);
      r = '0;
      for (int b = DW - 1; b >= 0; b--) begin
        t = r | (DW'(1) << b);
        lhs = 128'(t) * 128'(t) * 128'(d2);
        if (lhs <= c2) r = t;
      end
      a.distance = r;
    end
    return a;
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 5))
      0: return 'h8000;
      1: return 'h7fff;
      2: return int'($urandom_range(0, 64)) - 32;
      default: return int'($urandom);
    endcase
  endfunction

  task automatic push_query(input int px, py, sx, sy, ex, ey);
    query_t q;
    q.px = CW'(px); q.py = CW'(py);
    q.sx = CW'(sx); q.sy = CW'(sy);
    q.ex = CW'(ex); q.ey = CW'(ey);
    pending_queries.push_back(q);
  endtask

  // Driver: one transfer per edge where start is high and busy low
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_answers.push_back(segment_distance({in_point_x, in_point_y,
        in_seg_start_x, in_seg_start_y, in_seg_end_x, in_seg_end_y}));
    end
    if (rst_n && (!start || !busy)) begin
      if (pending_queries.size() > 0 && $urandom_range(1, 100) > idle_pct) begin
        query_t q;
        q = pending_queries.pop_front();
        start <= 1'b1;
        in_point_x <= q.px; in_point_y <= q.py;
        in_seg_start_x <= q.sx; in_seg_start_y <= q.sy;
        in_seg_end_x <= q.ex; in_seg_end_y <= q.ey;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result dist=%0d region=%0d", $time,
          out_distance, out_nearest_region);
        failed = 1;
      end else begin
        e = expected_answers.pop_front();
        if (out_distance !== e.distance) begin
          $display("%0t: distance expected %0d actual %0d", $time, e.distance,
            out_distance);
          failed = 1;
        end
        if (out_nearest_region !== e.region) begin
          $display("%0t: region expected %0d actual %0d", $time, e.region,
            out_nearest_region);
          failed = 1;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int m;
    m = 'h8000;
    // Directed: extremes, zero-length segment, each region
    push_query(0, 0, 0, 0, 0, 0);
    push_query('h7fff, 'h7fff, m, m, m, m);
    push_query(m, m, 'h7fff, 'h7fff, 'h7fff, 'h7fff);
    push_query(m, 'h7fff, 'h7fff, m, 'h7fff, m);
    push_query(-5, 0, 0, 0, 10, 0);
    push_query(15, 3, 0, 0, 10, 0);
    push_query(5, 7, 0, 0, 10, 0);
    push_query(5, -7, 0, 0, 10, 0);
    push_query(0, 0, m, m, 'h7fff, 'h7fff);
    push_query(m, 'h7fff, m, m, 'h7fff, 'h7fff);
    push_query('h7fff, m, m, m, 'h7fff, 'h7fff);
    push_query('hffff, 'hffff, 0, 0, 0, 0);
    push_query(10, 0, 0, 0, 10, 0);
    push_query(0, 5, 0, 0, 10, 0);
    push_query('h5555, 'haaaa, 'haaaa, 'h5555, 'h1234, 'hfedc);
    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < 135; i++) begin
        if (i % 5 == 0)
          push_query(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
            rand_coord(), rand_coord());
        else
          push_query(int'($urandom), int'($urandom), int'($urandom),
            int'($urandom), int'($urandom), int'($urandom));
      end
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // Sender idling phases, each running until its share of the queue has been sent
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 87 : (ph == 3) ? 37 : 0;
      while (pending_queries.size() > 150 * (3 - ph) + 1 && ph < 3) @(posedge clk);
    end
    while (pending_queries.size() > 0 || start || expected_answers.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (!failed && expected_answers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
